// ===== rtl/fcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcp_pkg: shared definitions for the thread queue with class promotion
// Depth, widths, request and status codes, entry layout, the command and
// status groups between controller and datapath, and slot arithmetic.
// ----------------------------------------------------------------------------
package fcp_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);

    // Request codes
    localparam logic [1:0] REQ_ENQ     = 2'd0;
    localparam logic [1:0] REQ_DEQ     = 2'd1;
    localparam logic [1:0] REQ_REORDER = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    // Class that gets promoted, and how many entries move at most
    localparam logic [1:0] TOP_CLASS   = 2'd1;
    localparam logic [1:0] PROMOTE_MAX = 2'd2;

    typedef struct packed {
        logic [31:0] handle;
        logic [15:0] id;
        logic [1:0]  cls;
    } entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic enq_write;
        logic flag_over;
        logic flag_under;
        logic deq_read;
        logic deq_pop;
        logic scan_init;
        logic scan_read;
        logic scan_check;
        logic mv_init;
        logic mv_second;
        logic mv_save;
        logic mv_read;
        logic mv_write;
        logic mv_put;
        logic load_result;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       is_top;
        logic       scan_last;
        logic [1:0] found;
        logic       k_at_t;
        logic       k_near_t;
        logic       res_free;
    } stat_t;

    // Physical slot of queue position pos, given the head slot
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/fcp_req_if.sv =====
// ----------------------------------------------------------------------------
// fcp_req_if: request channel
// Valid/ready channel that carries one queue request per transfer.
// ----------------------------------------------------------------------------
interface fcp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] thread_handle;
    logic [15:0] thread_id;
    logic [1:0]  entry_class;

    modport source (output valid, output req_type, output thread_handle,
                    output thread_id, output entry_class, input ready);
    modport sink   (input valid, input req_type, input thread_handle,
                    input thread_id, input entry_class, output ready);
endinterface

// ===== rtl/fcp_res_if.sv =====
// ----------------------------------------------------------------------------
// fcp_res_if: result channel
// Valid/ready channel that carries one request result per transfer.
// ----------------------------------------------------------------------------
interface fcp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [15:0] out_id;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output out_handle,
                    output out_id, output occupancy, input ready);
    modport sink   (input valid, input status, input out_handle,
                    input out_id, input occupancy, output ready);
endinterface

// ===== rtl/fifo_with_class_promotion.sv =====
// ----------------------------------------------------------------------------
// fifo_with_class_promotion: thread queue with top-class promotion
// Bounded FIFO of thread entries; enqueue, dequeue, and a reorder that
// moves the first two class-1 entries to the front in stable order.
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    req_type, thread_handle, thread_id,
//                                    entry_class
//   res      out  res.valid/ready    status, out_handle, out_id, occupancy
//
// One request is in work at a time. An enqueue runs S_ENQ, S_RESP; a dequeue
// S_DEQ_RD, S_DEQ_POP, S_RESP (no S_DEQ_POP if empty); a no-op S_RESP. A
// reorder runs S_SCAN_RD, S_SCAN_CHK per scanned entry, then per move
// S_MV_INIT, S_MV_SAVE, S_MV_RD and S_MV_WR per position moved, and S_MV_PUT;
// the entry memory with registered read takes one access at a time, one read
// and one write per shifted entry. The result sits in an output register, so
// the next request transfers while it waits; a stalled result holds the block
// before its next result only. Reset clears head, count and control at once.
// ----------------------------------------------------------------------------
module fifo_with_class_promotion (
    input  logic       clk,
    input  logic       rst_n,
    fcp_req_if.sink    req,
    fcp_res_if.source  res
);

    fcp_pkg::cmd_t  cmd;
    fcp_pkg::stat_t stat;

    fcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fcp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .thread_handle (req.thread_handle),
        .thread_id     (req.thread_id),
        .entry_class   (req.entry_class),
        .cmd           (cmd),
        .stat          (stat),
        .res           (res)
    );

`ifndef SYNTHESIS
    // Underflow only reports an empty queue
    a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status == fcp_pkg::ST_UNDER)) |-> (res.occupancy == 5'd0))
        else $error("underflow result with nonzero occupancy");

    // Overflow only reports a full queue
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status == fcp_pkg::ST_OVER))
            |-> (res.occupancy == 5'(fcp_pkg::QUEUE_DEPTH)))
        else $error("overflow result without full occupancy");

    // Failed requests carry no entry
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status != fcp_pkg::ST_OK))
            |-> ((res.out_handle == 32'd0) && (res.out_id == 16'd0)))
        else $error("error result carries entry data");

    // Count never reads full and empty at once
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !stat.empty)
        else $error("queue both full and empty");
`endif

endmodule

// ===== rtl/fcp_datapath.sv =====
// ----------------------------------------------------------------------------
// fcp_datapath: entry store, pointers and result register
// Holds the circular entry memory, head and count, the scan and move
// cursors for promotion, the pending result and the output register.
// ----------------------------------------------------------------------------
module fcp_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      thread_handle,
    input  logic [15:0]      thread_id,
    input  logic [1:0]       entry_class,
    input  fcp_pkg::cmd_t    cmd,
    output fcp_pkg::stat_t   stat,
    fcp_res_if.source        res
);

    fcp_pkg::entry_t mem [fcp_pkg::QUEUE_DEPTH];

    fcp_pkg::entry_t                  req_reg;
    fcp_pkg::entry_t                  rd_data_reg;
    fcp_pkg::entry_t                  save_reg;
    logic [fcp_pkg::IDX_W-1:0]        head_reg;
    logic [fcp_pkg::CNT_W-1:0]        count_reg;
    logic [fcp_pkg::IDX_W-1:0]        cursor_reg;
    logic [1:0]                       found_reg;
    logic [fcp_pkg::IDX_W-1:0]        p1_reg;
    logic [fcp_pkg::IDX_W-1:0]        p2_reg;
    logic [fcp_pkg::IDX_W-1:0]        k_reg;
    logic [fcp_pkg::IDX_W-1:0]        t_reg;
    logic [1:0]                       pend_status_reg;
    logic [31:0]                      pend_handle_reg;
    logic [15:0]                      pend_id_reg;
    logic                             out_valid_reg;
    logic [1:0]                       out_status_reg;
    logic [31:0]                      out_handle_reg;
    logic [15:0]                      out_id_reg;
    logic [4:0]                       out_occ_reg;

    logic                             rd_en;
    logic [fcp_pkg::IDX_W-1:0]        rd_addr;
    logic                             wr_en;
    logic [fcp_pkg::IDX_W-1:0]        wr_addr;
    fcp_pkg::entry_t                  wr_data;
    logic [fcp_pkg::IDX_W-1:0]        mv_src;
    logic [31:0]                      occ_wide;

    // Pick the position a move starts from
    assign mv_src = cmd.mv_second ? p2_reg : p1_reg;

    // Select the read address
    always_comb
    begin
        rd_en   = cmd.deq_read | cmd.scan_read | cmd.mv_init | cmd.mv_read;
        rd_addr = head_reg;
        if (cmd.scan_read)
        begin
            rd_addr = fcp_pkg::slot_of(head_reg, cursor_reg);
        end
        else if (cmd.mv_init)
        begin
            rd_addr = fcp_pkg::slot_of(head_reg, mv_src);
        end
        else if (cmd.mv_read)
        begin
            rd_addr = fcp_pkg::slot_of(head_reg, k_reg - fcp_pkg::IDX_W'(1));
        end
    end

    // Select the write address and data
    always_comb
    begin
        wr_en   = cmd.enq_write | cmd.mv_write | cmd.mv_put;
        wr_addr = fcp_pkg::slot_of(head_reg, count_reg[fcp_pkg::IDX_W-1:0]);
        wr_data = req_reg;
        if (cmd.mv_write)
        begin
            wr_addr = fcp_pkg::slot_of(head_reg, k_reg);
            wr_data = rd_data_reg;
        end
        else if (cmd.mv_put)
        begin
            wr_addr = fcp_pkg::slot_of(head_reg, t_reg);
            wr_data = save_reg;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Latch request payload, cursors, saved entry and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg.handle  <= thread_handle;
            req_reg.id      <= thread_id;
            req_reg.cls     <= entry_class;
            pend_status_reg <= fcp_pkg::ST_OK;
            pend_handle_reg <= '0;
            pend_id_reg     <= '0;
        end
        if (cmd.flag_over)
        begin
            pend_status_reg <= fcp_pkg::ST_OVER;
        end
        if (cmd.flag_under)
        begin
            pend_status_reg <= fcp_pkg::ST_UNDER;
        end
        if (cmd.deq_pop)
        begin
            pend_handle_reg <= rd_data_reg.handle;
            pend_id_reg     <= rd_data_reg.id;
        end
        if (cmd.scan_init)
        begin
            cursor_reg <= '0;
        end
        if (cmd.scan_check)
        begin
            cursor_reg <= cursor_reg + fcp_pkg::IDX_W'(1);
            if (stat.is_top)
            begin
                if (found_reg == 2'd0)
                begin
                    p1_reg <= cursor_reg;
                end
                else
                begin
                    p2_reg <= cursor_reg;
                end
            end
        end
        if (cmd.mv_init)
        begin
            k_reg <= mv_src;
            t_reg <= cmd.mv_second ? fcp_pkg::IDX_W'(1) : '0;
        end
        if (cmd.mv_save)
        begin
            save_reg <= rd_data_reg;
        end
        if (cmd.mv_write)
        begin
            k_reg <= k_reg - fcp_pkg::IDX_W'(1);
        end
    end

    // Advance head, count and promotion tally
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            found_reg <= '0;
        end
        else
        begin
            if (cmd.enq_write)
            begin
                count_reg <= count_reg + fcp_pkg::CNT_W'(1);
            end
            if (cmd.deq_pop)
            begin
                count_reg <= count_reg - fcp_pkg::CNT_W'(1);
                if (count_reg == fcp_pkg::CNT_W'(1))
                begin
                    head_reg <= '0;
                end
                else
                begin
                    head_reg <= fcp_pkg::slot_of(head_reg, fcp_pkg::IDX_W'(1));
                end
            end
            if (cmd.scan_init)
            begin
                found_reg <= '0;
            end
            if (cmd.scan_check && stat.is_top)
            begin
                found_reg <= found_reg + 2'd1;
            end
        end
    end

    // Hold the result until the sink takes it
    assign occ_wide = 32'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_status_reg <= pend_status_reg;
            out_handle_reg <= pend_handle_reg;
            out_id_reg     <= pend_id_reg;
            out_occ_reg    <= occ_wide[4:0];
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.status     = out_status_reg;
    assign res.out_handle = out_handle_reg;
    assign res.out_id     = out_id_reg;
    assign res.occupancy  = out_occ_reg;

    // Report status to the controller
    always_comb
    begin
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg >= fcp_pkg::CNT_W'(fcp_pkg::QUEUE_DEPTH));
        stat.is_top    = (rd_data_reg.cls == fcp_pkg::TOP_CLASS);
        stat.scan_last = ((fcp_pkg::CNT_W'(cursor_reg) + fcp_pkg::CNT_W'(1)) == count_reg);
        stat.found     = found_reg;
        stat.k_at_t    = (k_reg == t_reg);
        stat.k_near_t  = (k_reg == (t_reg + fcp_pkg::IDX_W'(1)));
        stat.res_free  = !out_valid_reg || res.ready;
    end

endmodule

// ===== rtl/fcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcp_ctrl: request sequencer
// Takes one request at a time and steps the datapath through enqueue,
// dequeue, the class scan and the shift moves of a promotion.
// ----------------------------------------------------------------------------
module fcp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_type,
    output logic             req_ready,
    input  fcp_pkg::stat_t   stat,
    output fcp_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENQ      = 4'd1;
    localparam logic [3:0] S_DEQ_RD   = 4'd2;
    localparam logic [3:0] S_DEQ_POP  = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CHK = 4'd5;
    localparam logic [3:0] S_MV_INIT  = 4'd6;
    localparam logic [3:0] S_MV_SAVE  = 4'd7;
    localparam logic [3:0] S_MV_RD    = 4'd8;
    localparam logic [3:0] S_MV_WR    = 4'd9;
    localparam logic [3:0] S_MV_PUT   = 4'd10;
    localparam logic [3:0] S_RESP     = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       second_reg;
    logic       second_next;
    logic       req_fire;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;

    // Decode state into datapath commands
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        second_next = second_reg;
        cmd.mv_second = second_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd.accept    = 1'b1;
                    cmd.scan_init = 1'b1;
                    unique case (req_type)
                        fcp_pkg::REQ_ENQ:     state_next = S_ENQ;
                        fcp_pkg::REQ_DEQ:     state_next = S_DEQ_RD;
                        fcp_pkg::REQ_REORDER: state_next = stat.empty ? S_RESP : S_SCAN_RD;
                        default:              state_next = S_RESP;
                    endcase
                end
            end
            S_ENQ:
            begin
                if (stat.full)
                begin
                    cmd.flag_over = 1'b1;
                end
                else
                begin
                    cmd.enq_write = 1'b1;
                end
                state_next = S_RESP;
            end
            S_DEQ_RD:
            begin
                if (stat.empty)
                begin
                    cmd.flag_under = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.deq_read = 1'b1;
                    state_next   = S_DEQ_POP;
                end
            end
            S_DEQ_POP:
            begin
                cmd.deq_pop = 1'b1;
                state_next  = S_RESP;
            end
            S_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_check = 1'b1;
                if ((stat.is_top && (stat.found == fcp_pkg::PROMOTE_MAX - 2'd1))
                    || stat.scan_last)
                begin
                    second_next = 1'b0;
                    if (!stat.is_top && (stat.found == 2'd0))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MV_INIT;
                    end
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_MV_INIT:
            begin
                cmd.mv_init = 1'b1;
                state_next  = S_MV_SAVE;
            end
            S_MV_SAVE:
            begin
                cmd.mv_save = 1'b1;
                state_next  = stat.k_at_t ? S_MV_PUT : S_MV_RD;
            end
            S_MV_RD:
            begin
                cmd.mv_read = 1'b1;
                state_next  = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.mv_write = 1'b1;
                state_next   = stat.k_near_t ? S_MV_PUT : S_MV_RD;
            end
            S_MV_PUT:
            begin
                cmd.mv_put = 1'b1;
                if (!second_reg && (stat.found == fcp_pkg::PROMOTE_MAX))
                begin
                    second_next = 1'b1;
                    state_next  = S_MV_INIT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (stat.res_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule
